@@ design/pc_charset_crlf_recoder_defines.svh @@
// Assertion macros for the PC code page / Latin-1 recoder.
// Used by the top level only; the bodies are empty for synthesis.
`ifndef PC_CHARSET_CRLF_RECODER_DEFINES_SVH
`define PC_CHARSET_CRLF_RECODER_DEFINES_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge out of reset
`define PCCR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never be seen out of reset
`define PCCR_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define PCCR_ASSERT(lbl, prop, msg)
`define PCCR_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

@@ design/pccr_pkg.sv @@
// Shared types, codes and helper functions of the recoder.
// No dependencies; used by the translator, the result queue and the top level.
`default_nettype none

package pccr_pkg;

    // Item opcodes
    localparam logic [1:0] OP_DATA = 2'd0;
    localparam logic [1:0] OP_END  = 2'd1;
    localparam logic [1:0] OP_LOAD = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_DIRECTION = 2'd0;
    localparam logic [1:0] CFG_STRICT    = 2'd1;
    localparam logic [1:0] CFG_RULER     = 2'd2;
    localparam int         CFG_DATA_W    = 1;

    // Translation table geometry: 8-bit value plus valid bit
    localparam int TBL_W     = 9;
    localparam int TBL_DEPTH = 256;

    // Result queue depth default
    localparam int RES_FIFO_DEPTH = 4;

    // Control characters
    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_SUB = 8'h1A;

    // Box-drawing range and its ASCII replacements
    localparam logic [7:0] RULER_FIRST = 8'd176;
    localparam logic [7:0] RULER_LAST  = 8'd223;
    localparam logic [7:0] ART_HASH  = 8'h23;
    localparam logic [7:0] ART_BAR   = 8'h7C;
    localparam logic [7:0] ART_PLUS  = 8'h2B;
    localparam logic [7:0] ART_DOT   = 8'h2E;
    localparam logic [7:0] ART_QUOTE = 8'h27;
    localparam logic [7:0] ART_TICK  = 8'h60;
    localparam logic [7:0] ART_DASH  = 8'h2D;
    localparam logic [7:0] ART_EQ    = 8'h3D;

    typedef struct packed {
        logic direction;
        logic strict_mode;
        logic ruler_overlay;
    } cfg_t;

    typedef struct packed {
        logic cr_pending;
        logic reversible;
        logic stopped;
    } st_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       is_final;
        logic       reversible;
        logic       last;
    } res_t;

    // Outcome of one table translation
    typedef struct packed {
        logic       emit;
        logic [7:0] value;
        logic       clr_rev;
    } xl_t;

    // ASCII art for box-drawing offset 0..47
    function automatic logic [7:0] ruler_art(input logic [5:0] idx);
        logic [7:0] c;
        case (idx)
            6'd0, 6'd1, 6'd2, 6'd43, 6'd44, 6'd45, 6'd46, 6'd47:
                c = ART_HASH;
            6'd3, 6'd5, 6'd9, 6'd10, 6'd22, 6'd28:
                c = ART_BAR;
            6'd4, 6'd6, 6'd17, 6'd18, 6'd19, 6'd21, 6'd23, 6'd32, 6'd34, 6'd39:
                c = ART_PLUS;
            6'd7, 6'd8, 6'd11, 6'd15, 6'd25, 6'd37, 6'd38, 6'd42:
                c = ART_DOT;
            6'd12, 6'd13, 6'd14, 6'd41:
                c = ART_QUOTE;
            6'd16, 6'd24, 6'd35, 6'd36:
                c = ART_TICK;
            6'd20:
                c = ART_DASH;
            6'd26, 6'd27, 6'd29, 6'd30, 6'd31, 6'd33, 6'd40:
                c = ART_EQ;
            default:
                c = CH_NUL;
        endcase
        return c;
    endfunction

    // Translate one byte through its table entry
    function automatic xl_t translate(input logic [7:0] b, input logic [TBL_W-1:0] e,
                                      input logic allow_ruler, input cfg_t cfg);
        xl_t        r;
        logic [7:0] off;
        off       = b - RULER_FIRST;
        r.emit    = 1'b1;
        r.value   = e[7:0];
        r.clr_rev = 1'b0;
        if (cfg.strict_mode)
        begin
            r.emit    = e[8];
            r.clr_rev = ~e[8];
        end
        else if (allow_ruler && cfg.ruler_overlay && (b inside {[RULER_FIRST:RULER_LAST]}))
        begin
            r.value = ruler_art(off[5:0]);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ design/pccr_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pccr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ design/pccr_xlat.sv @@
// Translation stage: stream state and the per-item result logic.
// Depends on pccr_pkg; fed by the table RAM read data and the CR entry copy.
`default_nettype none

module pccr_xlat (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           advance,
    input  wire logic [1:0]                     op,
    input  wire logic [7:0]                     item_byte,
    input  wire logic [pccr_pkg::TBL_W-1:0]     entry,
    input  wire logic [pccr_pkg::TBL_W-1:0]     cr_entry,
    input  wire pccr_pkg::cfg_t                 cfg,
    output logic      [1:0]                     push_cnt,
    output pccr_pkg::res_t                      push0,
    output pccr_pkg::res_t                      push1,
    output pccr_pkg::st_t                       st
);

    logic cr_pending_reg, cr_pending_next;
    logic rev_reg,        rev_next;
    logic stopped_reg,    stopped_next;

    pccr_pkg::xl_t t_cr;
    pccr_pkg::xl_t t_b;
    pccr_pkg::res_t res_a;
    pccr_pkg::res_t res_b;

    logic       a_v, b_v, b_fin, pc_step;
    logic [7:0] a_byte, b_byte;

    // Candidate results: slot a (flushed CR or first byte), slot b (byte or status)
    always_comb
    begin
        t_cr = pccr_pkg::translate(pccr_pkg::CH_CR, cr_entry, 1'b1, cfg);
        t_b  = pccr_pkg::translate(item_byte, entry, cfg.direction, cfg);

        a_v             = 1'b0;
        a_byte          = pccr_pkg::CH_NUL;
        b_v             = 1'b0;
        b_byte          = pccr_pkg::CH_NUL;
        b_fin           = 1'b0;
        pc_step         = 1'b0;
        cr_pending_next = cr_pending_reg;
        rev_next        = rev_reg;
        stopped_next    = stopped_reg;

        case (op)
            pccr_pkg::OP_DATA:
            begin
                if (!stopped_reg)
                begin
                    if (!cfg.direction)
                    begin
                        // Latin-1 to PC: LF expands to CR LF
                        if (item_byte == pccr_pkg::CH_LF)
                        begin
                            a_v    = 1'b1;
                            a_byte = pccr_pkg::CH_CR;
                            b_v    = 1'b1;
                            b_byte = pccr_pkg::CH_LF;
                        end
                        else
                        begin
                            a_v      = t_b.emit;
                            a_byte   = t_b.value;
                            rev_next = rev_reg & ~t_b.clr_rev;
                        end
                    end
                    else
                    begin
                        pc_step = 1'b1;
                        if (cr_pending_reg)
                        begin
                            cr_pending_next = 1'b0;
                            if (item_byte == pccr_pkg::CH_LF)
                            begin
                                // CR LF collapses to LF
                                a_v     = 1'b1;
                                a_byte  = pccr_pkg::CH_LF;
                                pc_step = 1'b0;
                            end
                            else
                            begin
                                a_v      = t_cr.emit;
                                a_byte   = t_cr.value;
                                rev_next = rev_reg & ~t_cr.clr_rev;
                            end
                        end
                        // PC to Latin-1 handling of the byte itself
                        if (pc_step)
                        begin
                            if (item_byte == pccr_pkg::CH_SUB)
                            begin
                                stopped_next = 1'b1;
                                rev_next     = 1'b0;
                            end
                            else if (item_byte == pccr_pkg::CH_CR)
                            begin
                                cr_pending_next = 1'b1;
                            end
                            else
                            begin
                                if (item_byte == pccr_pkg::CH_LF)
                                begin
                                    rev_next = 1'b0;
                                end
                                b_v      = t_b.emit;
                                b_byte   = t_b.value;
                                rev_next = rev_next & ~t_b.clr_rev;
                            end
                        end
                    end
                end
            end
            pccr_pkg::OP_END:
            begin
                // Flush a waiting CR, then the status result
                if (cr_pending_reg && cfg.direction && !stopped_reg)
                begin
                    a_v      = t_cr.emit;
                    a_byte   = t_cr.value;
                    rev_next = rev_reg & ~t_cr.clr_rev;
                end
                b_v   = 1'b1;
                b_fin = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // Pack the two slots into the queue push
    always_comb
    begin
        res_a.out_byte   = a_byte;
        res_a.has_byte   = 1'b1;
        res_a.is_final   = 1'b0;
        res_a.reversible = rev_next;
        res_a.last       = ~b_v;

        res_b.out_byte   = b_byte;
        res_b.has_byte   = ~b_fin;
        res_b.is_final   = b_fin;
        res_b.reversible = rev_next;
        res_b.last       = 1'b1;

        push0    = a_v ? res_a : res_b;
        push1    = res_b;
        push_cnt = {1'b0, a_v} + {1'b0, b_v};
    end

    // Stream state; end of stream restores the reset values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cr_pending_reg <= 1'b0;
            rev_reg        <= 1'b1;
            stopped_reg    <= 1'b0;
        end
        else if (advance)
        begin
            if (op == pccr_pkg::OP_END)
            begin
                cr_pending_reg <= 1'b0;
                rev_reg        <= 1'b1;
                stopped_reg    <= 1'b0;
            end
            else
            begin
                cr_pending_reg <= cr_pending_next;
                rev_reg        <= rev_next;
                stopped_reg    <= stopped_next;
            end
        end
    end

    assign st.cr_pending = cr_pending_reg;
    assign st.reversible = rev_reg;
    assign st.stopped    = stopped_reg;

endmodule

`default_nettype wire

@@ design/pccr_res_fifo.sv @@
// Result queue: takes up to two results per cycle, hands out one.
// Depends on pccr_pkg for the result type.
`default_nettype none

module pccr_res_fifo #(
    parameter int DEPTH = pccr_pkg::RES_FIFO_DEPTH
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [1:0]                   push_cnt,
    input  wire pccr_pkg::res_t               push0,
    input  wire pccr_pkg::res_t               push1,
    output logic                              room,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output pccr_pkg::res_t                    head,
    output logic      [$clog2(DEPTH+1)-1:0]   level
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    pccr_pkg::res_t entry_reg [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next, wr_ptr1;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    // Pointer and fill bookkeeping
    always_comb
    begin
        pop         = out_valid && out_ready;
        wr_ptr1     = ptr_inc(wr_ptr_reg);
        wr_ptr_next = wr_ptr_reg;
        if (push_cnt == 2'd1)
        begin
            wr_ptr_next = wr_ptr1;
        end
        else if (push_cnt == 2'd2)
        begin
            wr_ptr_next = ptr_inc(wr_ptr1);
        end
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push_cnt) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            if ((push_cnt != 2'd0) && (wr_ptr_reg == PTR_W'(i)))
            begin
                entry_reg[i] <= push0;
            end
            else if ((push_cnt == 2'd2) && (wr_ptr1 == PTR_W'(i)))
            begin
                entry_reg[i] <= push1;
            end
        end
    end

    assign room      = (count_reg <= CNT_W'(DEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];
    assign level     = count_reg;

endmodule

`default_nettype wire

@@ design/pc_charset_crlf_recoder.sv @@
// Byte stream recoder between a PC code page and Latin-1, driven by a
// 256-entry translation table that the host loads through load items. The
// block accepts one item per clock cycle; items pass through a stage
// register, and results leave one per cycle, while out_ready is high,
// through a four-entry result queue. An item yields zero, one or two results;
// items that yield two (LF in the Latin-1 to PC direction, a held CR flushed
// ahead of another byte or of the end-of-stream status) take two turns of
// the single output port, so the sustained rate is one result per cycle
// and input stalls only when the queue lacks room for two results. The table
// needs no clearing after reset; entries must be loaded before they are used.
// Depends on pccr_pkg, pccr_ram, pccr_xlat, pccr_res_fifo and the defines header.
`default_nettype none
`include "pc_charset_crlf_recoder_defines.svh"

module pc_charset_crlf_recoder #(
    parameter int RES_FIFO_DEPTH = pccr_pkg::RES_FIFO_DEPTH
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // configuration write port
    input  wire logic                               cfg_we,
    input  wire logic [1:0]                         cfg_index,
    input  wire logic [pccr_pkg::CFG_DATA_W-1:0]    cfg_data,
    // input items
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [1:0]                         opcode,
    input  wire logic [7:0]                         in_byte,
    input  wire logic [7:0]                         entry_value,
    input  wire logic                               entry_valid,
    // result items
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic      [7:0]                         out_byte,
    output logic                                    has_byte,
    output logic                                    is_final,
    output logic                                    reversible,
    output logic                                    last
);

    localparam int LEVEL_W = $clog2(RES_FIFO_DEPTH + 1);

    pccr_pkg::cfg_t cfg_reg;

    logic                         in_accept;
    logic                         s1_valid_reg, s1_valid_next;
    logic [1:0]                   s1_op_reg;
    logic [7:0]                   s1_byte_reg;
    logic                         s1_advance;
    logic [pccr_pkg::TBL_W-1:0]   tbl_rdata;
    logic [pccr_pkg::TBL_W-1:0]   cr_entry_reg;
    logic [1:0]                   push_cnt;
    pccr_pkg::res_t               push0, push1, head;
    pccr_pkg::st_t                core_st;
    logic                         fifo_room;
    logic [LEVEL_W-1:0]           fifo_level;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.direction     <= 1'b1;
            cfg_reg.strict_mode   <= 1'b0;
            cfg_reg.ruler_overlay <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pccr_pkg::CFG_DIRECTION: cfg_reg.direction     <= cfg_data[0];
                pccr_pkg::CFG_STRICT:    cfg_reg.strict_mode   <= cfg_data[0];
                pccr_pkg::CFG_RULER:     cfg_reg.ruler_overlay <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // Input handshake and the stage register in front of the translator
    assign in_accept  = in_valid && in_ready;
    assign s1_advance = s1_valid_reg && fifo_room;
    assign in_ready   = !s1_valid_reg || s1_advance;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_op_reg   <= opcode;
            s1_byte_reg <= in_byte;
        end
    end

    // Copy of the CR entry, so a flushed CR and the new byte translate together
    always_ff @(posedge clk)
    begin
        if (in_accept && (opcode == pccr_pkg::OP_LOAD) && (in_byte == pccr_pkg::CH_CR))
        begin
            cr_entry_reg <= {entry_valid, entry_value};
        end
    end

    // Translation table: loaded and read at item accept
    pccr_ram #(
        .WIDTH (pccr_pkg::TBL_W),
        .DEPTH (pccr_pkg::TBL_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (in_accept && (opcode == pccr_pkg::OP_LOAD)),
        .waddr (in_byte),
        .wdata ({entry_valid, entry_value}),
        .re    (in_accept && (opcode == pccr_pkg::OP_DATA)),
        .raddr (in_byte),
        .rdata (tbl_rdata)
    );

    pccr_xlat u_xlat (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (s1_advance),
        .op        (s1_op_reg),
        .item_byte (s1_byte_reg),
        .entry     (tbl_rdata),
        .cr_entry  (cr_entry_reg),
        .cfg       (cfg_reg),
        .push_cnt  (push_cnt),
        .push0     (push0),
        .push1     (push1),
        .st        (core_st)
    );

    pccr_res_fifo #(
        .DEPTH (RES_FIFO_DEPTH)
    ) u_res_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_cnt  (s1_advance ? push_cnt : 2'd0),
        .push0     (push0),
        .push1     (push1),
        .room      (fifo_room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head),
        .level     (fifo_level)
    );

    assign out_byte   = head.out_byte;
    assign has_byte   = head.has_byte;
    assign is_final   = head.is_final;
    assign reversible = head.reversible;
    assign last       = head.last;

    // Checks
    `PCCR_ASSERT(a_level_bound, fifo_level <= LEVEL_W'(RES_FIFO_DEPTH), "result queue overfilled")
    `PCCR_ASSERT_NEVER(a_stopped_quiet, s1_advance && core_st.stopped && (s1_op_reg == pccr_pkg::OP_DATA) && (push_cnt != 2'd0), "result from data while stopped")
    `PCCR_ASSERT(a_eos_restores, s1_advance && (s1_op_reg == pccr_pkg::OP_END) |=> core_st.reversible && !core_st.cr_pending && !core_st.stopped, "stream state not restored after end of stream")

endmodule

`default_nettype wire
